// File: hw/rtl/cdx_pkg.sv
// ----------------------------------------------------------------------------
// cdx_pkg: shared definitions for the Chebyshev divide-by-(x-1) core
// Field widths, default capacity and the accumulator control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package cdx_pkg;

  // Default series capacity
  localparam int MAX_COEFS_DEF = 64;

  // Payload widths
  localparam int COEF_W = 32;
  localparam int RES_W  = 48;
  localparam int TAIL_W = 40;

  // Control bundle from the sequencer to the shared accumulator
  typedef struct packed {
    logic clear;      // zero tail and weighted sums
    logic add_tail;   // tail_sum += coefficient
    logic add_wsum;   // weighted_sum += tail_sum
  } acc_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/cdx_in_if.sv
// ----------------------------------------------------------------------------
// cdx_in_if: coefficient input channel
// Valid/ready channel carrying one input coefficient and its end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdx_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [cdx_pkg::COEF_W-1:0] coef_in;
  logic                              last;

  modport source (output valid, output coef_in, output last, input ready);
  modport sink   (input valid, input coef_in, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cdx_out_if.sv
// ----------------------------------------------------------------------------
// cdx_out_if: result output channel
// Valid/ready channel carrying one result coefficient and its flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdx_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cdx_pkg::RES_W-1:0] coef_out;
  logic                             last_out;
  logic                             overflow;

  modport source (output valid, output coef_out, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input coef_out, input last_out, input overflow,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cdx_accum.sv
// ----------------------------------------------------------------------------
// cdx_accum: shared accumulator
// One 48-bit adder, used in turn for the tail sum and the weighted sum.
// ----------------------------------------------------------------------------
`default_nettype none

module cdx_accum (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire cdx_pkg::acc_ctrl_t                ctrl,
  input  wire logic signed [cdx_pkg::COEF_W-1:0] coef,
  output logic signed [cdx_pkg::RES_W-1:0]       wsum
);

  localparam int RW = cdx_pkg::RES_W;
  localparam int CW = cdx_pkg::COEF_W;
  localparam int TW = cdx_pkg::TAIL_W;

  logic signed [TW-1:0] tail_sum;
  logic signed [RW-1:0] weighted_sum;
  logic signed [RW-1:0] op_a;
  logic signed [RW-1:0] op_b;
  logic signed [RW-1:0] sum;

  // Select adder operands: tail + coef, or weighted + tail
  always_comb begin
    if (ctrl.add_tail) begin
      op_a = {{(RW-TW){tail_sum[TW-1]}}, tail_sum};
      op_b = {{(RW-CW){coef[CW-1]}}, coef};
    end else begin
      op_a = weighted_sum;
      op_b = {{(RW-TW){tail_sum[TW-1]}}, tail_sum};
    end
  end

  assign sum = op_a + op_b;

  // Update the running sums
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      tail_sum     <= '0;
      weighted_sum <= '0;
    end else if (ctrl.add_tail) begin
      tail_sum <= sum[TW-1:0];
    end else if (ctrl.add_wsum) begin
      weighted_sum <= sum;
    end
  end

  assign wsum = weighted_sum;

endmodule

`default_nettype wire

// File: hw/rtl/chebyshev_divide_by_x_minus_one_core.sv
// ----------------------------------------------------------------------------
// chebyshev_divide_by_x_minus_one_core: Chebyshev series divide by (x-1)
// Loads a coefficient series, then emits the series of [f(x)-f(1)]/(x-1).
// ----------------------------------------------------------------------------
// Coefficients are taken one per cycle until the item flagged last; up to
// MAX_COEFS are stored and any beyond are dropped, which sets overflow on
// every result of that series. After the last item the input is held off
// while a backward pass over the n stored coefficients runs through one
// shared adder, which alternates between the tail sum and the weighted sum.
// The results then leave in index order, paced by the registered read of the
// result memory and by any output stall. The final result sits in an output
// register, so a new series starts loading while it waits to be taken.
`default_nettype none

module chebyshev_divide_by_x_minus_one_core #(
  parameter int MAX_COEFS = cdx_pkg::MAX_COEFS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  cdx_in_if.sink   coef_ch,
  cdx_out_if.source res_ch
);

  localparam int IDX_W = $clog2(MAX_COEFS);
  localparam int CNT_W = $clog2(MAX_COEFS + 1);
  localparam int CW    = cdx_pkg::COEF_W;
  localparam int RW    = cdx_pkg::RES_W;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_CREAD = 6'b000010,
    S_CTAIL = 6'b000100,
    S_CWSUM = 6'b001000,
    S_EREAD = 6'b010000,
    S_ESEND = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Load bookkeeping
  logic [CNT_W-1:0] cnt;
  logic             dropped;
  logic             ovf;
  logic [IDX_W-1:0] k_top;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] e;

  // Memories
  logic signed [CW-1:0] coef_mem [MAX_COEFS];
  logic signed [RW-1:0] res_mem  [MAX_COEFS];
  logic signed [CW-1:0] coef_rd;
  logic signed [RW-1:0] res_rd;
  logic [IDX_W-1:0]     coef_raddr;

  // Output register
  logic                 out_valid;
  logic signed [RW-1:0] out_coef;
  logic                 out_last;
  logic                 out_ovf;

  logic                 in_xfer;
  logic                 has_room;
  logic                 load_out;
  logic signed [RW-1:0] wsum;
  logic signed [RW-1:0] res_wr;
  cdx_pkg::acc_ctrl_t   acc_ctrl;

  assign coef_ch.ready = (state == S_LOAD);
  assign in_xfer       = coef_ch.valid && coef_ch.ready;
  assign has_room      = (cnt < CNT_W'(MAX_COEFS));
  assign load_out      = (state == S_ESEND) && (!out_valid || res_ch.ready);

  // Shared accumulator
  always_comb begin
    acc_ctrl          = '0;
    acc_ctrl.clear    = in_xfer && coef_ch.last;
    acc_ctrl.add_tail = (state == S_CTAIL);
    acc_ctrl.add_wsum = (state == S_CWSUM);
  end

  cdx_accum u_accum (
    .clk  (clk),
    .rst  (rst),
    .ctrl (acc_ctrl),
    .coef (coef_rd),
    .wsum (wsum)
  );

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:  if (in_xfer && coef_ch.last) state_next = S_CREAD;
      S_CREAD: state_next = S_CTAIL;
      S_CTAIL: state_next = S_CWSUM;
      S_CWSUM: state_next = (k == '0) ? S_EREAD : S_CTAIL;
      S_EREAD: state_next = S_ESEND;
      S_ESEND: begin
        if (load_out) state_next = (e == k_top) ? S_LOAD : S_EREAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Count the load, record drops, set up the backward pass
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      dropped <= 1'b0;
    end else if (in_xfer) begin
      if (coef_ch.last) begin
        cnt     <= '0;
        dropped <= 1'b0;
      end else if (has_room) begin
        cnt <= cnt + 1'b1;
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && coef_ch.last) begin
      ovf   <= dropped || !has_room;
      k_top <= has_room ? cnt[IDX_W-1:0] : IDX_W'(MAX_COEFS - 1);
      k     <= has_room ? cnt[IDX_W-1:0] : IDX_W'(MAX_COEFS - 1);
    end else if (state == S_CWSUM && k != '0) begin
      k <= k - 1'b1;
    end
  end

  // Emit index: start at zero, advance on each output load
  always_ff @(posedge clk) begin
    if (state == S_CWSUM) begin
      e <= '0;
    end else if (load_out) begin
      e <= e + 1'b1;
    end
  end

  // Coefficient memory: write on load, registered read
  assign coef_raddr = (state == S_CWSUM) ? (k - 1'b1) : k;

  always_ff @(posedge clk) begin
    if (in_xfer && has_room) begin
      coef_mem[cnt[IDX_W-1:0]] <= coef_ch.coef_in;
    end
    coef_rd <= coef_mem[coef_raddr];
  end

  // Result memory: top entry is zero, entry zero unscaled, others doubled
  always_comb begin
    if (k == k_top) begin
      res_wr = '0;
    end else if (k == '0) begin
      res_wr = wsum;
    end else begin
      res_wr = wsum <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CTAIL) begin
      res_mem[k] <= res_wr;
    end
    res_rd <= res_mem[e];
  end

  // Output register: load on room, drop valid on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (res_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_coef <= res_rd;
      out_last <= (e == k_top);
      out_ovf  <= ovf;
    end
  end

  assign res_ch.valid    = out_valid;
  assign res_ch.coef_out = out_coef;
  assign res_ch.last_out = out_last;
  assign res_ch.overflow = out_ovf;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_COEFS))
    else $error("load count beyond capacity");

  a_end_of_load: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && coef_ch.last) |=> (cnt == '0 && !dropped))
    else $error("load state not cleared after last coefficient");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CTAIL || state == S_CWSUM) |-> (k <= k_top))
    else $error("compute index above top of series");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (load_out && e == k_top) |=> (state == S_LOAD && out_valid && out_last))
    else $error("final result did not return to load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res_ch.ready) |-> !load_out)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
